// ===== src/ptt_pkg.sv =====
// shared types and constants for the periodic timer table
`default_nettype none

package ptt_pkg;

    // table size and derived widths
    localparam int MAX_TIMERS = 16;
    localparam int IDX_W      = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;
    localparam int CNT_W      = $clog2(MAX_TIMERS + 1);

    // command op codes
    localparam logic [1:0] OP_ADD  = 2'd0;
    localparam logic [1:0] OP_KILL = 2'd1;
    localparam logic [1:0] OP_TICK = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ADD  = 2'd0;
    localparam logic [1:0] KIND_KILL = 2'd1;
    localparam logic [1:0] KIND_FIRE = 2'd2;

    // one input item
    typedef struct packed {
        logic [1:0]  op;
        logic [31:0] amount;
        logic [31:0] repeat_limit;
        logic [31:0] timer_id;
    } t_cmd;

    // one result item
    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] timer_id_res;
        logic [31:0] fire_count;
        logic        retired;
        logic        found;
        logic        last;
    } t_res;

    // one timer slot as held in the slot memory
    typedef struct packed {
        logic [31:0] id;
        logic [31:0] period;
        logic [31:0] limit;
        logic [31:0] count;
        logic [31:0] elapsed;
    } t_slot;

endpackage

`default_nettype wire

// ===== src/periodic_timer_table.sv =====
// periodic timer table: slot memory, slot scanner and result sequencing
//
// channel   | direction | handshake                 | payload
// command   | in        | start high, busy low      | i_cmd   (ptt_pkg::t_cmd)
// result    | out       | o_res_valid, one cycle    | o_res   (ptt_pkg::t_res)
//
// kill and tick hold busy for a scan: one slot read per cycle, two compute
// stages and a wrap-up step; any final item is registered as busy falls; a
// rejected add (zero period or full table) skips the scan, else each id probe
// is one such scan, a probe that hits a live id rescans, at most MAX_TIMERS
// probes; fire items are held back by one so the final one can carry last
// reset clears valid bits, id counter and control; results cannot be held off
`default_nettype none

module periodic_timer_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire ptt_pkg::t_cmd i_cmd,
    output logic               o_res_valid,
    output ptt_pkg::t_res      o_res
);
    import ptt_pkg::*;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } t_state;

    t_state                r_state;
    logic [MAX_TIMERS-1:0] r_valid;
    logic [31:0]           r_next_id;
    t_cmd                  r_cmd;
    logic [31:0]           r_target;
    logic [IDX_W-1:0]      r_free_idx;
    logic [CNT_W-1:0]      r_scan_cnt;
    logic                  r_conflict;
    logic                  r_found;

    // slot memory and its registered read data
    t_slot                 r_mem [MAX_TIMERS];
    t_slot                 r_rdata;

    // stage 1 follows the read, stage 2 follows stage 1
    logic                  r_s1_vld;
    logic [IDX_W-1:0]      r_s1_idx;
    logic                  r_s2_vld;
    logic [IDX_W-1:0]      r_s2_idx;
    logic                  r_s2_live;
    logic                  r_s2_hit;
    t_slot                 r_s2_slot;
    logic [31:0]           r_s2_sum;
    logic [31:0]           r_s2_cnt1;

    // held fire item and output register
    logic                  r_hold_vld;
    t_res                  r_hold;
    logic                  r_out_vld;
    t_res                  r_out;

    logic                  accept;
    logic                  issue;
    logic                  drained;
    logic                  s1_live;
    logic                  s1_hit;
    logic [32:0]           s1_sum_w;
    logic [31:0]           s1_sum;
    logic                  s2_tick;
    logic                  s2_fire;
    logic                  s2_retire;
    t_res                  s2_item;
    t_res                  hold_last;
    logic [IDX_W-1:0]      free_idx;
    logic                  full;
    logic                  mem_we;
    logic [IDX_W-1:0]      mem_waddr;
    t_slot                 mem_wdata;

    // next id after x, skipping zero
    function automatic logic [31:0] next_cand(input logic [31:0] x);
        logic [31:0] y;
        y = x + 32'd1;
        if (y == 32'd0) begin
            y = 32'd1;
        end
        return y;
    endfunction

    assign busy        = (r_state != ST_IDLE);
    assign accept      = start && !busy;
    assign o_res_valid = r_out_vld;
    assign o_res       = r_out;

    // lowest free slot
    always_comb begin
        free_idx = '0;
        for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_idx = IDX_W'(i);
            end
        end
    end
    assign full = &r_valid;

    // scan control
    assign issue   = (r_state == ST_SCAN) && (r_scan_cnt < CNT_W'(MAX_TIMERS));
    assign drained = (r_state == ST_SCAN) && !issue && !r_s1_vld && !r_s2_vld;

    // stage 1: id compare and saturating elapsed sum
    assign s1_live  = r_valid[r_s1_idx];
    assign s1_hit   = s1_live && (r_rdata.id == r_target);
    assign s1_sum_w = {1'b0, r_rdata.elapsed} + {1'b0, r_cmd.amount};
    assign s1_sum   = s1_sum_w[32] ? '1 : s1_sum_w[31:0];

    // stage 2: fire and retire decisions
    assign s2_tick   = r_s2_vld && r_s2_live && (r_cmd.op == OP_TICK);
    assign s2_fire   = s2_tick && (r_s2_sum >= r_s2_slot.period);
    assign s2_retire = s2_fire && (r_s2_slot.limit != 32'd0) &&
                       (r_s2_cnt1 >= r_s2_slot.limit);

    always_comb begin
        s2_item.kind         = KIND_FIRE;
        s2_item.timer_id_res = r_s2_slot.id;
        s2_item.fire_count   = r_s2_cnt1;
        s2_item.retired      = s2_retire;
        s2_item.found        = 1'b0;
        s2_item.last         = 1'b0;
    end

    // held fire item marked as the final one
    always_comb begin
        hold_last      = r_hold;
        hold_last.last = 1'b1;
    end

    // memory write: tick write-back, or a new slot when an add commits
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_s2_idx;
        mem_wdata = r_s2_slot;
        if (s2_tick) begin
            mem_we            = 1'b1;
            mem_wdata.count   = s2_fire ? r_s2_cnt1 : r_s2_slot.count;
            mem_wdata.elapsed = s2_fire ? 32'd0 : r_s2_sum;
        end else if (drained && (r_cmd.op == OP_ADD) && !r_conflict) begin
            mem_we            = 1'b1;
            mem_waddr         = r_free_idx;
            mem_wdata.id      = r_target;
            mem_wdata.period  = r_cmd.amount;
            mem_wdata.limit   = r_cmd.repeat_limit;
            mem_wdata.count   = 32'd0;
            mem_wdata.elapsed = 32'd0;
        end
    end

    // slot memory
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rdata <= r_mem[r_scan_cnt[IDX_W-1:0]];
        end
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
    end

    // sequencer, scan pipeline and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_valid    <= '0;
            r_next_id  <= 32'd0;
            r_scan_cnt <= '0;
            r_s1_vld   <= 1'b0;
            r_s2_vld   <= 1'b0;
            r_hold_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            r_out_vld <= 1'b0;

            // pipeline advance
            r_s1_vld  <= issue;
            r_s1_idx  <= r_scan_cnt[IDX_W-1:0];
            r_s2_vld  <= r_s1_vld;
            r_s2_idx  <= r_s1_idx;
            r_s2_live <= s1_live;
            r_s2_hit  <= s1_hit;
            r_s2_slot <= r_rdata;
            r_s2_sum  <= s1_sum;
            r_s2_cnt1 <= r_rdata.count + 32'd1;
            if (issue) begin
                r_scan_cnt <= r_scan_cnt + CNT_W'(1);
            end

            // stage 2 effects
            if (r_s2_vld && r_s2_hit && (r_cmd.op == OP_KILL)) begin
                r_valid[r_s2_idx] <= 1'b0;
                r_found           <= 1'b1;
            end
            if (r_s2_vld && r_s2_hit && (r_cmd.op == OP_ADD)) begin
                r_conflict <= 1'b1;
            end
            if (s2_retire) begin
                r_valid[r_s2_idx] <= 1'b0;
            end
            if (s2_fire) begin
                r_hold     <= s2_item;
                r_hold_vld <= 1'b1;
                if (r_hold_vld) begin
                    r_out_vld <= 1'b1;
                    r_out     <= r_hold;
                end
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (accept) begin
                        r_cmd      <= i_cmd;
                        r_scan_cnt <= '0;
                        r_conflict <= 1'b0;
                        r_found    <= 1'b0;
                        r_free_idx <= free_idx;
                        unique case (i_cmd.op)
                            OP_ADD: begin
                                if ((i_cmd.amount == 32'd0) || full) begin
                                    r_out_vld          <= 1'b1;
                                    r_out.kind         <= KIND_ADD;
                                    r_out.timer_id_res <= 32'd0;
                                    r_out.fire_count   <= 32'd0;
                                    r_out.retired      <= 1'b0;
                                    r_out.found        <= 1'b0;
                                    r_out.last         <= 1'b1;
                                end else begin
                                    r_target <= next_cand(r_next_id);
                                    r_state  <= ST_SCAN;
                                end
                            end
                            OP_KILL: begin
                                r_target <= i_cmd.timer_id;
                                r_state  <= ST_SCAN;
                            end
                            OP_TICK: begin
                                r_state <= ST_SCAN;
                            end
                            default: begin
                                // unused op code, dropped
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (drained) begin
                        unique case (r_cmd.op)
                            OP_ADD: begin
                                if (r_conflict) begin
                                    // probe the next id with a fresh scan
                                    r_target   <= next_cand(r_target);
                                    r_conflict <= 1'b0;
                                    r_scan_cnt <= '0;
                                end else begin
                                    r_valid[r_free_idx] <= 1'b1;
                                    r_next_id           <= r_target;
                                    r_out_vld           <= 1'b1;
                                    r_out.kind          <= KIND_ADD;
                                    r_out.timer_id_res  <= r_target;
                                    r_out.fire_count    <= 32'd0;
                                    r_out.retired       <= 1'b0;
                                    r_out.found         <= 1'b0;
                                    r_out.last          <= 1'b1;
                                    r_state             <= ST_IDLE;
                                end
                            end
                            OP_KILL: begin
                                r_out_vld          <= 1'b1;
                                r_out.kind         <= KIND_KILL;
                                r_out.timer_id_res <= r_cmd.timer_id;
                                r_out.fire_count   <= 32'd0;
                                r_out.retired      <= 1'b0;
                                r_out.found        <= r_found;
                                r_out.last         <= 1'b1;
                                r_state            <= ST_IDLE;
                            end
                            default: begin
                                // tick: release the held fire item as the final one
                                if (r_hold_vld) begin
                                    r_out_vld  <= 1'b1;
                                    r_out      <= hold_last;
                                    r_hold_vld <= 1'b0;
                                end
                                r_state <= ST_IDLE;
                            end
                        endcase
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    // scan pipeline is empty whenever the block is idle
    a_idle_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (!r_s1_vld && !r_s2_vld && !r_hold_vld))
        else $error("scan pipeline not empty while idle");

    // add and kill replies are always the final item
    a_reply_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && (o_res.kind == KIND_ADD || o_res.kind == KIND_KILL))
        |-> o_res.last)
        else $error("reply without last");

    // a fired timer always carries a nonzero id and a clear found flag
    a_fire_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_res.kind == KIND_FIRE)
        |-> (o_res.timer_id_res != 32'd0 && !o_res.found))
        else $error("bad fire item");

    // a new slot is only committed into a free slot
    a_commit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (drained && r_cmd.op == OP_ADD && !r_conflict) |-> !r_valid[r_free_idx])
        else $error("add committed into a live slot");

endmodule

`default_nettype wire
